// ===== rtl/mrev_pkg.sv =====
// Package: shared constants, state codes and helpers for the reversed-list merge block.
package mrev_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int LEN_W      = 5;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LEN_W;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_B = 1'b1;

    localparam logic SEL_LIST_A = 1'b0;
    localparam logic SEL_LIST_B = 1'b1;

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    // Length clamped to the store depth.
    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        if (int'(len) > LIST_DEPTH) begin
            return CNT_W'(LIST_DEPTH);
        end
        return CNT_W'(len);
    endfunction

endpackage

// ===== rtl/mrev_in_if.sv =====
// Interface: input item channel (list selector and element).
interface mrev_in_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [mrev_pkg::DATA_W-1:0] element;

    modport source (output valid, output req_type, output element, input ready);
    modport sink   (input valid, input req_type, input element, output ready);
endinterface

// ===== rtl/mrev_out_if.sv =====
// Interface: result item channel (merged value and last flag).
interface mrev_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mrev_pkg::DATA_W-1:0] merged_value;
    logic                              is_last;

    modport source (output valid, output merged_value, output is_last, input ready);
    modport sink   (input valid, input merged_value, input is_last, output ready);
endinterface

// ===== rtl/merge_ascending_with_reversed_list.sv =====
// Top level: loads an ascending list A and a descending list B, then emits their ascending merge.
//
// Items on i_item carry a list selector (req_type: 0 = A, 1 = B) and a signed
// 32-bit element. Each accepted item is written into that list's store, one
// item per cycle, until the list holds length_a / length_b elements (clamped
// to the store depth of 16); extra items for a full list are dropped. The item
// that completes both lists starts the merge: B is read from its last entry
// back to its first, so both lists run ascending, and the smaller head goes
// out each time, B winning ties; the rest of the longer list follows and the
// final result carries is_last. While merging, i_item is not ready. Each
// result is produced in two states: S_READ reads both store heads through the
// registered memory read ports, then S_EMIT compares and loads the output
// register, waiting there while the output side stalls. When both lengths are
// zero, every item starts an empty merge that returns nothing and the block
// stays in S_LOAD. Fill counts clear when a merge starts. The user must write
// lengths through the config port (index 0 = length_a, index 1 = length_b)
// only while the block is idle; the block itself does not enforce it.
module merge_ascending_with_reversed_list (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mrev_in_if.sink                           i_item,
    mrev_out_if.source                        o_result,
    input  logic                              i_cfg_we,
    input  logic [mrev_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mrev_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = mrev_pkg::ADDR_W;
    localparam int CW = mrev_pkg::CNT_W;
    localparam int DW = mrev_pkg::DATA_W;

    // List stores: one write port (load), one registered read port (merge).
    logic [DW-1:0] r_mem_a [mrev_pkg::LIST_DEPTH];
    logic [DW-1:0] r_mem_b [mrev_pkg::LIST_DEPTH];
    logic [DW-1:0] r_rd_a, r_rd_b;

    // Config
    logic [mrev_pkg::LEN_W-1:0] r_len_a, r_len_b;
    logic [CW-1:0]              la, lb;

    // Control
    mrev_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_fill_a, n_fill_a, r_fill_b, n_fill_b;
    logic [CW-1:0]    r_x, n_x, r_y, n_y;

    // Output register
    logic          r_out_valid, n_out_valid;
    logic [DW-1:0] r_out_value, n_out_value;
    logic          r_out_last, n_out_last;

    logic          accept;
    logic          wr_a, wr_b;
    logic          rd_en;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic [CW-1:0] b_idx;
    logic          a_live, b_live, take_a, out_free;
    logic [CW-1:0] fill_a_inc, fill_b_inc;

    assign la = mrev_pkg::eff_len(r_len_a);
    assign lb = mrev_pkg::eff_len(r_len_b);

    assign i_item.ready          = (r_state == mrev_pkg::S_LOAD);
    assign accept                = i_item.valid && i_item.ready;
    assign o_result.valid        = r_out_valid;
    assign o_result.merged_value = r_out_value;
    assign o_result.is_last      = r_out_last;

    // Append only while the selected list is short of its length.
    assign wr_a = accept && (i_item.req_type == mrev_pkg::SEL_LIST_A) && (r_fill_a < la);
    assign wr_b = accept && (i_item.req_type == mrev_pkg::SEL_LIST_B) && (r_fill_b < lb);
    assign fill_a_inc = wr_a ? r_fill_a + CW'(1) : r_fill_a;
    assign fill_b_inc = wr_b ? r_fill_b + CW'(1) : r_fill_b;

    // B runs reversed: head at lb-1-y. Out-of-range addresses are never used.
    assign b_idx     = lb - CW'(1) - r_y;
    assign rd_addr_a = r_x[AW-1:0];
    assign rd_addr_b = b_idx[AW-1:0];
    assign rd_en     = (r_state == mrev_pkg::S_READ);

    assign a_live   = (r_x < la);
    assign b_live   = (r_y < lb);
    assign take_a   = (a_live && b_live) ? ($signed(r_rd_a) < $signed(r_rd_b)) : a_live;
    assign out_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mem_a[r_fill_a[AW-1:0]] <= i_item.element;
        end
        if (rd_en) begin
            r_rd_a <= r_mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            r_mem_b[r_fill_b[AW-1:0]] <= i_item.element;
        end
        if (rd_en) begin
            r_rd_b <= r_mem_b[rd_addr_b];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill_a    = r_fill_a;
        n_fill_b    = r_fill_b;
        n_x         = r_x;
        n_y         = r_y;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;

        unique case (r_state)
            mrev_pkg::S_LOAD: begin
                if (accept) begin
                    n_fill_a = fill_a_inc;
                    n_fill_b = fill_b_inc;
                    // Both lists complete: start the merge (empty job emits nothing).
                    if ((fill_a_inc >= la) && (fill_b_inc >= lb)) begin
                        n_fill_a = '0;
                        n_fill_b = '0;
                        n_x      = '0;
                        n_y      = '0;
                        if ((la != '0) || (lb != '0)) begin
                            n_state = mrev_pkg::S_READ;
                        end
                    end
                end
            end
            mrev_pkg::S_READ: begin
                n_state = mrev_pkg::S_EMIT;
            end
            mrev_pkg::S_EMIT: begin
                // Hold the head data until the output register frees up.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (take_a) begin
                        n_out_value = r_rd_a;
                        n_x         = r_x + CW'(1);
                    end else begin
                        n_out_value = r_rd_b;
                        n_y         = r_y + CW'(1);
                    end
                    n_out_last = (n_x == la) && (n_y == lb);
                    n_state    = n_out_last ? mrev_pkg::S_LOAD : mrev_pkg::S_READ;
                end
            end
            default: begin
                n_state = mrev_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrev_pkg::S_LOAD;
            r_fill_a    <= '0;
            r_fill_b    <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_out_valid <= 1'b0;
            r_len_a     <= '0;
            r_len_b     <= '0;
        end else begin
            r_state     <= n_state;
            r_fill_a    <= n_fill_a;
            r_fill_b    <= n_fill_b;
            r_x         <= n_x;
            r_y         <= n_y;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mrev_pkg::REG_LENGTH_A: r_len_a <= i_cfg_data;
                    mrev_pkg::REG_LENGTH_B: r_len_b <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

endmodule
